### rtl/nmea_gga_position_parser_macros.svh
// Assertion macros for the GGA position parser.
// Each macro expects clk and arst_n in scope.
`ifndef NMEA_GGA_POSITION_PARSER_MACROS_SVH
`define NMEA_GGA_POSITION_PARSER_MACROS_SVH

// Condition must hold in the same cycle as the trigger.
`define NGGA_ASSERT_SAME(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error(msg);

// Condition must hold in the cycle after the trigger.
`define NGGA_ASSERT_NEXT(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

### rtl/ngga_pkg.sv
`timescale 1ns / 1ps
package ngga_pkg;

	localparam int FRACTION_DIGITS_DEF = 5;
	localparam int MAX_INT_DIGITS      = 5;
	localparam int HDR_LEN             = 6;
	localparam int QUEUE_DEPTH         = 4;
	localparam int QPTR_W              = $clog2(QUEUE_DEPTH);

	localparam int COORD_W     = 34;
	localparam int DEG_W       = 10;  // up to 999 degrees
	localparam int FRAC_W      = 24;  // minutes fraction in 1e-7 minute
	localparam int MIN_N_W     = 30;  // minutes in 1e-7 minute, below 1e9
	localparam int DIV_X_W     = MIN_N_W - 2;
	localparam int RECIP_W     = 29;
	localparam int RECIP_SHIFT = 32;
	localparam int PROD_W      = DIV_X_W + RECIP_W;
	localparam int QUOT_W      = 24;

	localparam logic [COORD_W-1:0] E7_SCALE  = 34'd10000000;
	localparam logic [COORD_W-1:0] COORD_MAX = 34'd9999999999;
	// floor(2^32 / 15)
	localparam logic [RECIP_W-1:0] RECIP15   = 29'd286331153;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_POINT  = 8'h2E;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	typedef enum logic [1:0] {
		STATUS_OK         = 2'd0,
		STATUS_FEW_TOKENS = 2'd1,
		STATUS_INT_DIGITS = 2'd2
	} status_t;

	// Coordinate kept as degrees, two BCD minute digits and scaled fraction.
	typedef struct packed {
		logic [DEG_W-1:0]  deg;
		logic [3:0]        min_hi;
		logic [3:0]        min_lo;
		logic [FRAC_W-1:0] frac;
	} coord_t;

	typedef struct packed {
		coord_t  lat;
		logic [7:0] ns;
		coord_t  lon;
		logic [7:0] ew;
		status_t status;
	} fix_rec_t;

	function automatic logic [7:0] hdr_char(input logic [2:0] pos);
		logic [7:0] c;
		unique case (pos)
			3'd0: c = 8'h24;  // $
			3'd1: c = 8'h47;  // G
			3'd2: c = 8'h4E;  // N
			3'd3: c = 8'h47;  // G
			3'd4: c = 8'h47;  // G
			3'd5: c = 8'h41;  // A
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [FRAC_W-1:0] pow10_w(input logic [2:0] n);
		logic [FRAC_W-1:0] p;
		unique case (n)
			3'd0: p = 24'd1;
			3'd1: p = 24'd10;
			3'd2: p = 24'd100;
			3'd3: p = 24'd1000;
			3'd4: p = 24'd10000;
			3'd5: p = 24'd100000;
			3'd6: p = 24'd1000000;
			default: p = 24'd0;
		endcase
		return p;
	endfunction

endpackage

### rtl/ngga_front.sv
`timescale 1ns / 1ps
module ngga_front #(
	parameter int FRACTION_DIGITS = ngga_pkg::FRACTION_DIGITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               data_valid,
	output logic               data_ready,
	input  logic [7:0]         data_byte,
	input  logic               queue_full,
	output logic               push,
	output ngga_pkg::fix_rec_t rec
);
	import ngga_pkg::*;

	localparam logic [2:0] FRAC_LIMIT = 3'(FRACTION_DIGITS);
	localparam logic [2:0] INT_LIMIT  = 3'(MAX_INT_DIGITS);
	localparam logic [2:0] HDR_END    = 3'(HDR_LEN);
	localparam logic [2:0] FRAC_TOP   = 3'd6;
	localparam logic [3:0] TOK_LAT    = 4'd2;
	localparam logic [3:0] TOK_NS     = 4'd3;
	localparam logic [3:0] TOK_LON    = 4'd4;
	localparam logic [3:0] TOK_EW     = 4'd5;
	localparam logic [3:0] TOK_MAX    = 4'd15;

	logic [2:0] hdr_pos_q, hdr_pos_d;
	logic       active_q, active_d;
	logic [3:0] tok_q, tok_d;
	logic       in_tok_q, in_tok_d;
	coord_t     lat_q, lat_d, lon_q, lon_d;
	logic [2:0] int_cnt_q, int_cnt_d;
	logic [2:0] frac_cnt_q, frac_cnt_d;
	logic       point_q, point_d;
	logic       stopped_q, stopped_d;
	logic       ovf_q, ovf_d;
	logic [7:0] ns_q, ns_d, ew_q, ew_d;
	logic       accept;

	assign data_ready = !queue_full;
	assign accept     = data_valid && data_ready;

	always_comb begin
		coord_t     cur;
		logic [2:0] hdr_nx;
		logic [3:0] digit;
		logic       is_digit;
		logic       clear;
		logic       start;

		hdr_pos_d  = hdr_pos_q;
		active_d   = active_q;
		tok_d      = tok_q;
		in_tok_d   = in_tok_q;
		lat_d      = lat_q;
		lon_d      = lon_q;
		int_cnt_d  = int_cnt_q;
		frac_cnt_d = frac_cnt_q;
		point_d    = point_q;
		stopped_d  = stopped_q;
		ovf_d      = ovf_q;
		ns_d       = ns_q;
		ew_d       = ew_q;
		push       = 1'b0;
		clear      = 1'b0;
		start      = 1'b0;
		hdr_nx     = 3'd0;
		cur        = lat_q;
		digit      = data_byte[3:0];
		is_digit   = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);

		if (accept) begin
			if (!active_q) begin
				// hunt for the header; a stray '$' restarts the match
				if (data_byte == hdr_char(hdr_pos_q)) begin
					hdr_nx = hdr_pos_q + 3'd1;
				end else if (data_byte == CH_DOLLAR) begin
					hdr_nx = 3'd1;
				end else begin
					hdr_nx = 3'd0;
				end
				hdr_pos_d = hdr_nx;
				if (hdr_nx == HDR_END) begin
					clear = 1'b1;
					start = 1'b1;
				end
			end else if (data_byte == CH_CR || data_byte == CH_LF) begin
				push  = 1'b1;
				clear = 1'b1;
			end else if (data_byte == CH_COMMA) begin
				in_tok_d = 1'b0;
			end else begin
				if (!in_tok_q) begin
					in_tok_d = 1'b1;
					if (tok_q != TOK_MAX) begin
						tok_d = tok_q + 4'd1;
					end
					if (tok_d == TOK_LAT || tok_d == TOK_LON) begin
						int_cnt_d  = 3'd0;
						frac_cnt_d = 3'd0;
						point_d    = 1'b0;
						stopped_d  = 1'b0;
					end
					if (tok_d == TOK_NS) begin
						ns_d = data_byte;
					end
					if (tok_d == TOK_EW) begin
						ew_d = data_byte;
					end
				end
				if (tok_d == TOK_LAT || tok_d == TOK_LON) begin
					cur = (tok_d == TOK_LAT) ? lat_q : lon_q;
					if (!stopped_d) begin
						if (is_digit) begin
							if (!point_d) begin
								if (int_cnt_d >= INT_LIMIT) begin
									ovf_d     = 1'b1;
									int_cnt_d = INT_LIMIT + 3'd1;
								end else begin
									// shift the digit through the two minute digits
									cur.deg = {cur.deg[DEG_W-4:0], 3'b000}
										+ {cur.deg[DEG_W-2:0], 1'b0}
										+ DEG_W'(cur.min_hi);
									cur.min_hi = cur.min_lo;
									cur.min_lo = digit;
									int_cnt_d  = int_cnt_d + 3'd1;
								end
							end else if (frac_cnt_d < FRAC_LIMIT) begin
								cur.frac = cur.frac
									+ FRAC_W'(digit) * pow10_w(FRAC_TOP - frac_cnt_d);
								frac_cnt_d = frac_cnt_d + 3'd1;
							end
						end else if (data_byte == CH_POINT && !point_d) begin
							point_d = 1'b1;
						end else begin
							stopped_d = 1'b1;
						end
					end
					if (tok_d == TOK_LAT) begin
						lat_d = cur;
					end else begin
						lon_d = cur;
					end
				end
			end
		end

		if (clear) begin
			hdr_pos_d  = 3'd0;
			active_d   = start;
			in_tok_d   = start;
			tok_d      = 4'd0;
			lat_d      = '0;
			lon_d      = '0;
			int_cnt_d  = 3'd0;
			frac_cnt_d = 3'd0;
			point_d    = 1'b0;
			stopped_d  = 1'b0;
			ovf_d      = 1'b0;
			ns_d       = 8'd0;
			ew_d       = 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_pos_q  <= 3'd0;
			active_q   <= 1'b0;
			tok_q      <= 4'd0;
			in_tok_q   <= 1'b0;
			lat_q      <= '0;
			lon_q      <= '0;
			int_cnt_q  <= 3'd0;
			frac_cnt_q <= 3'd0;
			point_q    <= 1'b0;
			stopped_q  <= 1'b0;
			ovf_q      <= 1'b0;
			ns_q       <= 8'd0;
			ew_q       <= 8'd0;
		end else begin
			hdr_pos_q  <= hdr_pos_d;
			active_q   <= active_d;
			tok_q      <= tok_d;
			in_tok_q   <= in_tok_d;
			lat_q      <= lat_d;
			lon_q      <= lon_d;
			int_cnt_q  <= int_cnt_d;
			frac_cnt_q <= frac_cnt_d;
			point_q    <= point_d;
			stopped_q  <= stopped_d;
			ovf_q      <= ovf_d;
			ns_q       <= ns_d;
			ew_q       <= ew_d;
		end
	end

	always_comb begin
		rec.lat = lat_q;
		rec.ns  = ns_q;
		rec.lon = lon_q;
		rec.ew  = ew_q;
		priority if (tok_q < TOK_EW) begin
			rec.status = STATUS_FEW_TOKENS;
		end else if (ovf_q) begin
			rec.status = STATUS_INT_DIGITS;
		end else begin
			rec.status = STATUS_OK;
		end
	end

endmodule

### rtl/ngga_fifo.sv
`timescale 1ns / 1ps
module ngga_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  ngga_pkg::fix_rec_t wr_rec,
	output logic               full,
	input  logic               pop,
	output logic               rd_valid,
	output ngga_pkg::fix_rec_t rd_rec
);
	import ngga_pkg::*;

	fix_rec_t            mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]     count_q;
	logic                do_push, do_pop;

	assign full     = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_rec   = mem_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && rd_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + (QPTR_W+1)'(1);
				2'b01:   count_q <= count_q - (QPTR_W+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### rtl/ngga_conv.sv
`timescale 1ns / 1ps
module ngga_conv (
	input  logic                         clk,
	input  logic                         en,
	input  ngga_pkg::coord_t             coord,
	output logic [ngga_pkg::COORD_W-1:0] e7
);
	import ngga_pkg::*;

	logic [COORD_W-1:0]  deg_e7_s1, deg_e7_s2, deg_e7_s3, e7_s4;
	logic [MIN_N_W-1:0]  minute_n_s1;
	logic [DIV_X_W-1:0]  x_s2;
	logic [PROD_W-1:0]   prod_s2;
	logic [QUOT_W-1:0]   quot_s3;

	logic [6:0]                     min_int;
	logic [PROD_W-RECIP_SHIFT-1:0]  q0;
	logic [DIV_X_W:0]               q0x15, rem;
	logic [PROD_W-RECIP_SHIFT-1:0]  q_fix;
	logic [COORD_W-1:0]             sum;

	assign min_int = 7'(coord.min_hi) * 7'd10 + 7'(coord.min_lo);

	// quotient by 15 from the reciprocal, low by at most one
	assign q0    = prod_s2[PROD_W-1:RECIP_SHIFT];
	assign q0x15 = (DIV_X_W+1)'({q0, 4'b0000}) - (DIV_X_W+1)'(q0);
	assign rem   = {1'b0, x_s2} - q0x15;
	assign q_fix = (rem >= (DIV_X_W+1)'(15)) ? q0 + 1'b1 : q0;

	assign sum = deg_e7_s3 + COORD_W'(quot_s3);
	assign e7  = e7_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			deg_e7_s1   <= COORD_W'(coord.deg) * E7_SCALE;
			minute_n_s1 <= MIN_N_W'(min_int) * MIN_N_W'(E7_SCALE) + MIN_N_W'(coord.frac);

			// minutes / 60 as (minutes / 4) / 15
			x_s2      <= minute_n_s1[MIN_N_W-1:2];
			prod_s2   <= PROD_W'(minute_n_s1[MIN_N_W-1:2]) * PROD_W'(RECIP15);
			deg_e7_s2 <= deg_e7_s1;

			quot_s3   <= QUOT_W'(q_fix);
			deg_e7_s3 <= deg_e7_s2;

			e7_s4 <= (sum > COORD_MAX) ? COORD_MAX : sum;
		end
	end

endmodule

### rtl/ngga_back.sv
`timescale 1ns / 1ps
module ngga_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_valid,
	input  ngga_pkg::fix_rec_t           q_rec,
	output logic                         pop,
	output logic                         result_valid,
	input  logic                         result_ready,
	output logic [ngga_pkg::COORD_W-1:0] latitude_e7,
	output logic [7:0]                   latitude_hemisphere,
	output logic [ngga_pkg::COORD_W-1:0] longitude_e7,
	output logic [7:0]                   longitude_hemisphere,
	output ngga_pkg::status_t            status
);
	import ngga_pkg::*;

	typedef struct packed {
		logic [7:0] ns;
		logic [7:0] ew;
		status_t    status;
	} side_t;

	logic               v_s1, v_s2, v_s3, v_s4;
	side_t              side_s1, side_s2, side_s3, side_s4;
	logic               en;
	logic               ok;
	logic [COORD_W-1:0] lat_e7, lon_e7;

	// whole pipe holds while the output register waits
	assign en  = !(v_s4 && !result_ready);
	assign pop = q_valid && en;

	ngga_conv u_lat (
		.clk   (clk),
		.en    (en),
		.coord (q_rec.lat),
		.e7    (lat_e7)
	);

	ngga_conv u_lon (
		.clk   (clk),
		.en    (en),
		.coord (q_rec.lon),
		.e7    (lon_e7)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= pop;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= '{ns: q_rec.ns, ew: q_rec.ew, status: q_rec.status};
			side_s2 <= side_s1;
			side_s3 <= side_s2;
			side_s4 <= side_s3;
		end
	end

	assign ok                   = (side_s4.status == STATUS_OK);
	assign result_valid         = v_s4;
	assign status               = side_s4.status;
	assign latitude_e7          = ok ? lat_e7 : '0;
	assign longitude_e7         = ok ? lon_e7 : '0;
	assign latitude_hemisphere  = ok ? side_s4.ns : 8'd0;
	assign longitude_hemisphere = ok ? side_s4.ew : 8'd0;

endmodule

### rtl/nmea_gga_position_parser.sv
`timescale 1ns / 1ps
// Channel  | Handshake                  | Payload
// ---------+----------------------------+------------------------------------------
// input    | data_valid / data_ready    | data_byte
// result   | result_valid / result_ready| latitude_e7, latitude_hemisphere,
//          |                            | longitude_e7, longitude_hemisphere, status
//
// One byte beat per cycle; data_ready drops only while the result queue holds
// four sentences whose results have not been taken.
// With the queue empty and no stall, the record of the sentence that a CR or LF
// beat ends passes through the queue and the conversion pipe before result_valid rises.
// The result side sustains one beat per cycle; a stall holds the four-stage
// conversion pipe while the byte side keeps running into the queue.
// Reset (arst_n low) clears the header matcher, sentence state and queue at once.
module nmea_gga_position_parser #(
	parameter int FRACTION_DIGITS = ngga_pkg::FRACTION_DIGITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         data_valid,
	output logic                         data_ready,
	input  logic [7:0]                   data_byte,
	output logic                         result_valid,
	input  logic                         result_ready,
	output logic [ngga_pkg::COORD_W-1:0] latitude_e7,
	output logic [7:0]                   latitude_hemisphere,
	output logic [ngga_pkg::COORD_W-1:0] longitude_e7,
	output logic [7:0]                   longitude_hemisphere,
	output ngga_pkg::status_t            status
);
	import ngga_pkg::*;

	// front side: header hunt, tokenizer and digit accumulation
	logic     push;
	logic     queue_full;
	fix_rec_t front_rec;

	// queue side
	logic     q_valid;
	logic     pop;
	fix_rec_t q_rec;

	// Track the header, split tokens, accumulate the two coordinates as
	// degrees plus minute digits; push one record per finished sentence.
	ngga_front #(
		.FRACTION_DIGITS (FRACTION_DIGITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.data_valid (data_valid),
		.data_ready (data_ready),
		.data_byte  (data_byte),
		.queue_full (queue_full),
		.push       (push),
		.rec        (front_rec)
	);

	// Decouple the byte side from result stalls.
	ngga_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_rec   (front_rec),
		.full     (queue_full),
		.pop      (pop),
		.rd_valid (q_valid),
		.rd_rec   (q_rec)
	);

	// Convert degree-minutes to 1e-7 degree, saturate, and hold the result beat.
	ngga_back u_back (
		.clk                  (clk),
		.arst_n               (arst_n),
		.q_valid              (q_valid),
		.q_rec                (q_rec),
		.pop                  (pop),
		.result_valid         (result_valid),
		.result_ready         (result_ready),
		.latitude_e7          (latitude_e7),
		.latitude_hemisphere  (latitude_hemisphere),
		.longitude_e7         (longitude_e7),
		.longitude_hemisphere (longitude_hemisphere),
		.status               (status)
	);

endmodule

### rtl/ngga_checker.sv
`timescale 1ns / 1ps
`include "nmea_gga_position_parser_macros.svh"
module ngga_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         data_valid,
	input logic                         data_ready,
	input logic [7:0]                   data_byte,
	input logic                         result_valid,
	input logic                         result_ready,
	input logic [ngga_pkg::COORD_W-1:0] latitude_e7,
	input logic [7:0]                   latitude_hemisphere,
	input logic [ngga_pkg::COORD_W-1:0] longitude_e7,
	input logic [7:0]                   longitude_hemisphere,
	input ngga_pkg::status_t            status
);
	import ngga_pkg::*;

	// a stalled result beat keeps its payload
	`NGGA_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(latitude_e7) && $stable(longitude_e7) && $stable(status), "result beat changed while stalled")

	// error results carry no position
	`NGGA_ASSERT_SAME(a_error_zero, result_valid && status != STATUS_OK, latitude_e7 == '0 && longitude_e7 == '0 && latitude_hemisphere == 8'd0 && longitude_hemisphere == 8'd0, "error result carries position data")

	// saturation bounds both coordinates
	`NGGA_ASSERT_SAME(a_coord_sat, result_valid, latitude_e7 <= COORD_MAX && longitude_e7 <= COORD_MAX, "coordinate above saturation limit")

endmodule

bind nmea_gga_position_parser ngga_checker u_ngga_checker (.*);

### tb/nmea_gga_position_parser_tb.sv
`timescale 1ns / 1ps
module nmea_gga_position_parser_tb;
	import ngga_pkg::*;

	localparam int CYCLE_LIMIT      = 1_000_000;
	localparam int RANDOM_BYTES     = 600;
	localparam int DRAIN_CYCLES     = 8;   // idle time after the last fix is checked
	localparam int MAX_REPORTS      = 40;

	// Sentence layout: token 0 is the header itself.
	localparam int LAT_TOKEN  = 2;
	localparam int NS_TOKEN   = 3;
	localparam int LON_TOKEN  = 4;
	localparam int EW_TOKEN   = 5;
	localparam int TOKEN_LAST = 15;

	localparam int FRAC_DIGITS        = FRACTION_DIGITS_DEF;
	localparam int MINUTES_PER_DEGREE = 60;
	localparam int DM_DEGREE_FACTOR   = 100;
	localparam longint unsigned DEG_E7 = 64'd10000000;
	localparam logic [8*HDR_LEN-1:0] GGA_HEADER = "$GNGGA";

	typedef struct packed {
		logic [COORD_W-1:0] lat_e7;
		logic [7:0]         lat_hemi;
		logic [COORD_W-1:0] lon_e7;
		logic [7:0]         lon_hemi;
		status_t            fix_status;
	} gga_fix_t;

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               data_valid   = 1'b0;
	logic               data_ready;
	logic [7:0]         data_byte    = 8'h00;
	logic               result_valid;
	logic               result_ready = 1'b0;
	logic [COORD_W-1:0] latitude_e7;
	logic [7:0]         latitude_hemisphere;
	logic [COORD_W-1:0] longitude_e7;
	logic [7:0]         longitude_hemisphere;
	status_t            status;

	nmea_gga_position_parser dut (
		.clk                  (clk),
		.arst_n               (arst_n),
		.data_valid           (data_valid),
		.data_ready           (data_ready),
		.data_byte            (data_byte),
		.result_valid         (result_valid),
		.result_ready         (result_ready),
		.latitude_e7          (latitude_e7),
		.latitude_hemisphere  (latitude_hemisphere),
		.longitude_e7         (longitude_e7),
		.longitude_hemisphere (longitude_hemisphere),
		.status               (status)
	);

	// Fixes predicted from accepted bytes, oldest first.
	gga_fix_t   pending_fixes[$];
	// Bytes staged for the sender.
	bit [7:0]   outgoing[$];

	int bytes_sent          = 0;
	int results_checked     = 0;
	int mismatch_count      = 0;
	int cycle_count         = 0;
	int result_hold_request = 0;
	bit gaps_enabled        = 1'b1;
	bit stalls_enabled      = 1'b1;

	// Parser state mirrored by the predictor; all of it clears to zero.
	bit [2:0]        hdr_pos;
	bit              in_sentence;
	bit [3:0]        tok_idx;
	bit              in_tok;
	longint unsigned lat_acc;
	longint unsigned lon_acc;
	int              int_digits;
	int              frac_digits;
	bit              saw_point;
	bit              num_done;
	bit              too_many_digits;
	bit [7:0]        ns_char;
	bit [7:0]        ew_char;

	initial begin
		forever #4 clk = ~clk;
	end

	//------------------------------------------------------------------
	// Predictor
	//------------------------------------------------------------------
	function automatic longint unsigned ten_to(int n);
		longint unsigned p = 1;
		for (int i = 0; i < n; i++)
			p = p * 10;
		return p;
	endfunction

	// ddmm.mmmmm (scaled by 10^FRAC_DIGITS) to degrees in 1e-7 units, saturated.
	function automatic logic [COORD_W-1:0] dm_to_e7(longint unsigned acc);
		longint unsigned scale;
		longint unsigned degrees;
		longint unsigned minutes;
		longint unsigned deg_e7;
		scale   = ten_to(FRAC_DIGITS);
		degrees = acc / (DM_DEGREE_FACTOR * scale);
		minutes = acc % (DM_DEGREE_FACTOR * scale);
		deg_e7  = degrees * DEG_E7 + (minutes * DEG_E7) / (MINUTES_PER_DEGREE * scale);
		if (deg_e7 > COORD_MAX)
			return COORD_MAX;
		return deg_e7[COORD_W-1:0];
	endfunction

	function automatic void start_coord();
		int_digits  = 0;
		frac_digits = 0;
		saw_point   = 1'b0;
		num_done    = 1'b0;
	endfunction

	function automatic void clear_sentence();
		hdr_pos         = '0;
		in_sentence     = 1'b0;
		tok_idx         = '0;
		in_tok          = 1'b0;
		lat_acc         = 0;
		lon_acc         = 0;
		too_many_digits = 1'b0;
		ns_char         = '0;
		ew_char         = '0;
		start_coord();
	endfunction

	// Fold one character of a coordinate token into its accumulator.
	function automatic longint unsigned add_coord_char(longint unsigned acc, bit [7:0] b);
		longint unsigned digit;
		if (num_done)
			return acc;
		digit = 64'(b - CH_ZERO);
		if (b >= CH_ZERO && b <= CH_NINE) begin
			if (!saw_point) begin
				// a sixth integer digit flags the sentence and is dropped
				if (int_digits >= MAX_INT_DIGITS) begin
					too_many_digits = 1'b1;
					int_digits      = MAX_INT_DIGITS + 1;
				end else begin
					acc        = acc * 10 + digit * ten_to(FRAC_DIGITS);
					int_digits = int_digits + 1;
				end
			end else if (frac_digits < FRAC_DIGITS) begin
				acc         = acc + digit * ten_to(FRAC_DIGITS - 1 - frac_digits);
				frac_digits = frac_digits + 1;
			end
		end else if (b == CH_POINT && !saw_point) begin
			saw_point = 1'b1;
		end else begin
			num_done = 1'b1;
		end
		return acc;
	endfunction

	// Advance the mirrored parser by one accepted byte; queue a fix at end of line.
	task automatic predict_byte(bit [7:0] b);
		gga_fix_t fix;
		if (!in_sentence) begin
			if (hdr_pos < HDR_LEN && b == GGA_HEADER[8*(HDR_LEN-1-hdr_pos) +: 8])
				hdr_pos = hdr_pos + 3'd1;
			else
				hdr_pos = (b == CH_DOLLAR) ? 3'd1 : 3'd0;
			if (hdr_pos >= HDR_LEN) begin
				clear_sentence();
				in_sentence = 1'b1;
				in_tok      = 1'b1;
			end
			return;
		end
		if (b == CH_CR || b == CH_LF) begin
			fix = '0;
			if (tok_idx < EW_TOKEN) begin
				fix.fix_status = STATUS_FEW_TOKENS;
			end else if (too_many_digits) begin
				fix.fix_status = STATUS_INT_DIGITS;
			end else begin
				fix.fix_status = STATUS_OK;
				fix.lat_e7     = dm_to_e7(lat_acc);
				fix.lat_hemi   = ns_char;
				fix.lon_e7     = dm_to_e7(lon_acc);
				fix.lon_hemi   = ew_char;
			end
			pending_fixes.push_back(fix);
			clear_sentence();
			return;
		end
		if (b == CH_COMMA) begin
			in_tok = 1'b0;
			return;
		end
		// first byte of a new token: empty tokens never get here
		if (!in_tok) begin
			in_tok = 1'b1;
			if (tok_idx < TOKEN_LAST)
				tok_idx = tok_idx + 4'd1;
			if (tok_idx == LAT_TOKEN || tok_idx == LON_TOKEN)
				start_coord();
			if (tok_idx == NS_TOKEN)
				ns_char = b;
			if (tok_idx == EW_TOKEN)
				ew_char = b;
		end
		if (tok_idx == LAT_TOKEN)
			lat_acc = add_coord_char(lat_acc, b);
		else if (tok_idx == LON_TOKEN)
			lon_acc = add_coord_char(lon_acc, b);
	endtask

	//------------------------------------------------------------------
	// Byte sender
	//------------------------------------------------------------------
	// Mostly back-to-back, sometimes a short gap, now and then a long pause.
	function automatic int random_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Offer one byte, hold it until the beat is taken, then predict from it.
	task automatic send_byte(bit [7:0] b);
		int gap;
		gap = gaps_enabled ? random_gap() : 0;
		if (gap > 0) begin
			data_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		data_valid <= 1'b1;
		data_byte  <= b;
		do @(posedge clk); while (!data_ready);
		predict_byte(b);
		bytes_sent++;
	endtask

	task automatic put_text(string s);
		for (int i = 0; i < s.len(); i++)
			outgoing.push_back(s[i]);
	endtask

	task automatic flush_outgoing();
		while (outgoing.size() != 0)
			send_byte(outgoing.pop_front());
	endtask

	task automatic send_line(string body, bit [7:0] term);
		put_text(body);
		outgoing.push_back(term);
		flush_outgoing();
	endtask

	// Drop valid and hold until every predicted fix has been checked.
	task automatic wait_fixes_drained();
		data_valid <= 1'b0;
		do @(posedge clk); while (pending_fixes.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	//------------------------------------------------------------------
	// Result receiver: random stalls, plus a long hold-off on request
	//------------------------------------------------------------------
	initial begin
		int hold;
		forever begin
			@(posedge clk);
			hold = 0;
			if (result_hold_request > 0) begin
				hold                = result_hold_request;
				result_hold_request = 0;
			end else if (stalls_enabled && $urandom_range(0, 3) == 0) begin
				hold = random_gap();
			end
			if (hold > 0) begin
				result_ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			result_ready <= 1'b1;
		end
	end

	//------------------------------------------------------------------
	// Checking
	//------------------------------------------------------------------
	task automatic report_mismatch(string what);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("MISMATCH at %0t ns: %s", $time, what);
	endtask

	// Compare every result beat against the oldest predicted fix.
	always @(posedge clk) begin : check_results
		gga_fix_t want;
		if (arst_n && result_valid && result_ready) begin
			results_checked++;
			if (pending_fixes.size() == 0) begin
				report_mismatch("result beat with no sentence pending");
			end else begin
				want = pending_fixes.pop_front();
				if (latitude_e7 !== want.lat_e7)
					report_mismatch($sformatf("latitude_e7 %0d, predicted %0d",
						latitude_e7, want.lat_e7));
				if (latitude_hemisphere !== want.lat_hemi)
					report_mismatch($sformatf("latitude_hemisphere %h, predicted %h",
						latitude_hemisphere, want.lat_hemi));
				if (longitude_e7 !== want.lon_e7)
					report_mismatch($sformatf("longitude_e7 %0d, predicted %0d",
						longitude_e7, want.lon_e7));
				if (longitude_hemisphere !== want.lon_hemi)
					report_mismatch($sformatf("longitude_hemisphere %h, predicted %h",
						longitude_hemisphere, want.lon_hemi));
				if (status !== want.fix_status)
					report_mismatch($sformatf("status %0d, predicted %0d",
						status, want.fix_status));
			end
		end
	end

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d fixes outstanding",
				cycle_count, pending_fixes.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	//------------------------------------------------------------------
	// Tests
	//------------------------------------------------------------------
	// Ordinary fixes, the coordinate extremes, and saturation of both outputs.
	task automatic test_plain_fixes();
		send_line("$GNGGA,092725.00,4717.11399,N,00833.91590,E,1,08,1.01,499.6,M,48.0,M,,",
			CH_CR);
		send_line("", CH_LF);
		send_line("$GNGGA,000000.00,0000.00000,S,00000.00000,W,0,00,99.9,0.0,M,0.0,M,,*4F",
			CH_LF);
		send_line("$GNGGA,235959.99,8959.99999,N,17959.99999,W,2,12,0.5,9000.0,M,1.0,0000*7A",
			CH_CR);
		send_line("$GNGGA,1,99999.99999,S,99999.99999,E", CH_LF);
		wait_fixes_drained();
	endtask

	// Truncated, short and malformed numbers; minutes past 60.
	task automatic test_number_forms();
		send_line("$GNGGA,t,4807.0380012345,N,01131.000009999,E", CH_CR);
		send_line("$GNGGA,t,48,N,011.5,E", CH_LF);
		send_line("$GNGGA,t,.25,N,7.,E", CH_CR);
		send_line("$GNGGA,t,12a34.5,N,-0113,E", CH_LF);
		send_line("$GNGGA,t,1e5,N,12.3.4,E", CH_CR);
		send_line("$GNGGA,t,abc,N,N,E", CH_LF);
		send_line("$GNGGA,t,4875.5,N,00099.99999,E", CH_CR);
		wait_fixes_drained();
	endtask

	// Short sentences, integer overflow on each coordinate, and their priority.
	task automatic test_error_status();
		send_line("$GNGGA", CH_CR);
		send_line("$GNGGA,1,2,N,3", CH_LF);
		send_line("$GNGGA,1,123456.0,N,3,E", CH_CR);
		send_line("$GNGGA,1,2,N,1234567,E,1", CH_LF);
		send_line("$GNGGA,1,123456,N", CH_CR);
		send_line("$GNGGA,1,2,N,3,E", CH_LF);
		wait_fixes_drained();
	endtask

	// Header matching, empty tokens, odd token content and token-count saturation.
	task automatic test_framing();
		send_line("", CH_CR);
		send_line("GNGGA,1,2,N,3,E", CH_LF);
		send_line("$GPGGA,1,2,N,3,E", CH_CR);
		send_line("$$GNGGA,1,4807.5,N,01131.5,E", CH_LF);
		send_line("$GNG$GNGGA,1,4807.5,S,01131.5,W", CH_CR);
		send_line("$GNGGAXYZ,1,,,2,,,N,,3,,E,,,,", CH_LF);
		// NUL as hemisphere, '$' cutting off the longitude
		put_text("$GNGGA,1,");
		outgoing.push_back(8'h00);
		put_text("2,");
		outgoing.push_back(8'h00);
		put_text(",$5,E");
		outgoing.push_back(CH_CR);
		flush_outgoing();
		send_line("$GNGGA,1,2,North,3,West,a,b,c,d,e,f,g,h,i,j,k,l,m,n,o", CH_CR);
		wait_fixes_drained();
	endtask

	// Hold results off long enough for the queue to fill and stall the byte side.
	task automatic test_backpressure();
		gaps_enabled        = 1'b0;
		stalls_enabled      = 1'b0;
		result_hold_request = 400;
		for (int i = 0; i < 16; i++)
			send_line($sformatf("$GNGGA,%0d,%0d.5,N,%0d,E", i, 100 + i, 2000 + i), CH_LF);
		wait_fixes_drained();
		gaps_enabled   = 1'b1;
		stalls_enabled = 1'b1;
	endtask

	// Any byte that a token may hold: everything but comma, CR and LF.
	function automatic bit [7:0] random_content_byte();
		bit [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b == CH_COMMA || b == CH_CR || b == CH_LF);
		return b;
	endfunction

	task automatic put_coord();
		int n_int;
		int n_frac;
		n_int  = ($urandom_range(0, 19) == 0) ? $urandom_range(6, 7) : $urandom_range(0, 5);
		n_frac = $urandom_range(0, 7);
		repeat (n_int) outgoing.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
		if (n_frac > 0 || $urandom_range(0, 1) == 1)
			outgoing.push_back(CH_POINT);
		repeat (n_frac) outgoing.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
		if ($urandom_range(0, 9) == 0)
			outgoing.push_back(random_content_byte());
	endtask

	task automatic put_hemisphere(string pair);
		if ($urandom_range(0, 9) < 8)
			outgoing.push_back(pair[$urandom_range(0, 1)]);
		else
			outgoing.push_back(random_content_byte());
		if ($urandom_range(0, 9) == 0)
			outgoing.push_back(random_content_byte());
	endtask

	// Stage one sentence of up to the given number of tokens after the header.
	task automatic put_random_sentence(int tokens);
		int term;
		put_text("$GNGGA");
		for (int t = 1; t <= tokens; t++) begin
			outgoing.push_back(CH_COMMA);
			if ($urandom_range(0, 15) == 0)
				outgoing.push_back(CH_COMMA);
			if (t == LAT_TOKEN || t == LON_TOKEN)
				put_coord();
			else if (t == NS_TOKEN)
				put_hemisphere("NS");
			else if (t == EW_TOKEN)
				put_hemisphere("EW");
			else
				repeat ($urandom_range(0, 4))
					outgoing.push_back(($urandom_range(0, 3) == 0) ?
						random_content_byte() : 8'(CH_ZERO + $urandom_range(0, 9)));
		end
		// mostly a proper line end; sometimes none, so the next line runs on
		term = $urandom_range(0, 19);
		if (term < 7) begin
			outgoing.push_back(CH_CR);
			outgoing.push_back(CH_LF);
		end else if (term < 13) begin
			outgoing.push_back(CH_CR);
		end else if (term < 19) begin
			outgoing.push_back(CH_LF);
		end
	endtask

	// Mostly complete sentences, some cut short, some raw line noise.
	task automatic test_random_stream();
		int bytes_at_start;
		int kind;
		bytes_at_start = bytes_sent;
		while (bytes_sent - bytes_at_start < RANDOM_BYTES) begin
			if ($urandom_range(0, 9) == 0) begin
				gaps_enabled   = ($urandom_range(0, 2) != 0);
				stalls_enabled = ($urandom_range(0, 2) != 0);
			end
			kind = $urandom_range(0, 99);
			if (kind < 70)
				put_random_sentence(EW_TOKEN + $urandom_range(1, 12));
			else if (kind < 85)
				put_random_sentence($urandom_range(0, EW_TOKEN));
			else
				repeat ($urandom_range(1, 24))
					outgoing.push_back(8'($urandom_range(0, 255)));
			flush_outgoing();
		end
		gaps_enabled   = 1'b1;
		stalls_enabled = 1'b1;
	endtask

	//------------------------------------------------------------------
	// Sequence
	//------------------------------------------------------------------
	initial begin
		clear_sentence();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_plain_fixes();
		test_number_forms();
		test_error_status();
		test_framing();
		test_backpressure();
		test_random_stream();

		wait_fixes_drained();
		repeat (20) @(posedge clk);

		$display("Sent %0d bytes and checked %0d fixes: plain and extreme coordinates,",
			bytes_sent, results_checked);
		$display("number edge forms, status codes, header framing, a long hold-off, random lines.");
		if (mismatch_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches", mismatch_count);
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

### files.f
+incdir+rtl
rtl/ngga_pkg.sv
rtl/ngga_front.sv
rtl/ngga_fifo.sv
rtl/ngga_conv.sv
rtl/ngga_back.sv
rtl/nmea_gga_position_parser.sv
rtl/ngga_checker.sv
tb/nmea_gga_position_parser_tb.sv
